[hdl/pwq_pkg.sv]
// ----------------------------------------------------------------------------
// pwq_pkg: shared types and constants of the priority warning queue
// Sizes of the entry store, field widths, operation and status codes, and the
// structs that run between the controller, the entry RAM and the top level.
// ----------------------------------------------------------------------------
package pwq_pkg;

	// Queue capacity and stored ID width.
	localparam int CAPACITY = 32;
	localparam int ID_BITS  = 8;

	// Fixed field widths of the stream words.
	localparam int ID_W    = 8;
	localparam int PRIO_W  = 16;
	localparam int TOTAL_W = 6;
	localparam int DATA_W  = 32;

	// Derived storage widths.
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = ID_BITS + PRIO_W;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_PEEK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_INSERT,
		S_HEAD,
		S_RESULT
	} state_t;

	// One access cycle of the entry RAM: one write port, one read port.
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} ram_req_t;

	// Result of one operation.
	typedef struct packed {
		logic               head_valid;
		logic [ID_W-1:0]    head_id;
		logic [PRIO_W-1:0]  head_priority;
		logic [TOTAL_W-1:0] entry_total;
		status_t            status;
	} rslt_t;

endpackage

[hdl/pwq_ram.sv]
// ----------------------------------------------------------------------------
// pwq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module pwq_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/pwq_ctrl.sv]
// ----------------------------------------------------------------------------
// pwq_ctrl: operation sequencer of the priority warning queue
// Scans the entry RAM for the ID and the insert position, shifts entries up
// or down through a registered read/write pipeline, writes the new entry and
// reads the head back for the result.
// ----------------------------------------------------------------------------
module pwq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pwq_pkg::mode_t                  in_mode,
	input  logic [pwq_pkg::ID_W-1:0]        in_id,
	input  logic [pwq_pkg::PRIO_W-1:0]      in_prio,
	output logic                            rslt_valid,
	input  logic                            rslt_ready,
	output pwq_pkg::rslt_t                  rslt,
	output pwq_pkg::ram_req_t               ram_req,
	input  logic [pwq_pkg::ENTRY_W-1:0]     ram_rdata
);

	import pwq_pkg::*;

	state_t              state_q, state_d;
	mode_t               mode_q;
	status_t             status_q;
	logic [ID_BITS-1:0]  id_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    scan_q;
	logic [CNT_W-1:0]    sh_q;
	logic [CNT_W-1:0]    sh_dec;
	logic [CNT_W-1:0]    sh_inc;
	logic [CNT_W-1:0]    at_inc;
	logic                pend_s1;
	logic [IDX_W-1:0]    tag_s1;
	logic [IDX_W-1:0]    tag_d;
	logic                found_q;
	logic [IDX_W-1:0]    at_q;
	logic                pos_found_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    ins_q;
	logic                issue;
	logic                drained;
	logic                accept;
	logic                full;
	logic [ID_BITS-1:0]  rd_id;
	logic [PRIO_W-1:0]   rd_prio;

	assign rd_id   = ram_rdata[ID_BITS-1:0];
	assign rd_prio = ram_rdata[ENTRY_W-1:ID_BITS];
	assign sh_dec  = sh_q - 1'b1;
	assign sh_inc  = sh_q + 1'b1;
	assign at_inc  = CNT_W'(at_q) + 1'b1;
	assign accept  = in_valid && in_ready;
	assign full    = (fill_q == CNT_W'(CAPACITY));
	assign drained = !issue && !pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ram_req    = '0;
		issue      = 1'b0;
		tag_d      = scan_q[IDX_W-1:0];
		in_ready   = 1'b0;
		rslt_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_mode)
						MODE_ADD, MODE_REMOVE: state_d = S_SCAN;
						MODE_CLEAR, MODE_PEEK: state_d = S_HEAD;
						default:               state_d = S_HEAD;
					endcase
				end
			end
			S_SCAN: begin
				issue         = (scan_q < fill_q);
				ram_req.re    = issue;
				ram_req.raddr = scan_q[IDX_W-1:0];
				if (drained) begin
					if (mode_q == MODE_ADD) begin
						state_d = (found_q || full) ? S_HEAD : S_SHIFT;
					end else begin
						state_d = found_q ? S_SHIFT : S_HEAD;
					end
				end
			end
			S_SHIFT: begin
				// Add moves entries up from the tail, remove moves them down.
				if (mode_q == MODE_ADD) begin
					issue         = (sh_q > CNT_W'(ins_q));
					ram_req.raddr = sh_dec[IDX_W-1:0];
					tag_d         = sh_q[IDX_W-1:0];
				end else begin
					issue         = (sh_q < fill_q);
					ram_req.raddr = sh_q[IDX_W-1:0];
					tag_d         = sh_dec[IDX_W-1:0];
				end
				ram_req.re    = issue;
				ram_req.we    = pend_s1;
				ram_req.waddr = tag_s1;
				ram_req.wdata = ram_rdata;
				if (drained) begin
					state_d = (mode_q == MODE_ADD) ? S_INSERT : S_HEAD;
				end
			end
			S_INSERT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ins_q;
				ram_req.wdata = {prio_q, id_q};
				state_d       = S_HEAD;
			end
			S_HEAD: begin
				ram_req.re    = (fill_q != '0);
				ram_req.raddr = '0;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				rslt_valid = 1'b1;
				if (rslt_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			pos_found_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (accept) begin
				found_q     <= 1'b0;
				pos_found_q <= 1'b0;
				if (in_mode == MODE_CLEAR) begin
					fill_q <= '0;
				end
			end
			if (state_q == S_SCAN && pend_s1) begin
				if (rd_id == id_q) begin
					found_q <= 1'b1;
				end
				if (!pos_found_q && prio_q >= rd_prio) begin
					pos_found_q <= 1'b1;
				end
			end
			if (state_q == S_INSERT) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == S_SHIFT && drained && mode_q == MODE_REMOVE) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Operand and pointer registers.
	always_ff @(posedge clk) begin
		tag_s1 <= tag_d;
		if (accept) begin
			mode_q   <= in_mode;
			id_q     <= in_id[ID_BITS-1:0];
			prio_q   <= in_prio;
			scan_q   <= '0;
			status_q <= ST_DONE;
		end
		if (state_q == S_SCAN) begin
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (pend_s1) begin
				if (rd_id == id_q) begin
					at_q <= tag_s1;
				end
				if (!pos_found_q && prio_q >= rd_prio) begin
					pos_q <= tag_s1;
				end
			end
			if (drained) begin
				if (mode_q == MODE_ADD) begin
					sh_q  <= fill_q;
					ins_q <= pos_found_q ? pos_q : fill_q[IDX_W-1:0];
					priority if (found_q) begin
						status_q <= ST_DUP;
					end else if (full) begin
						status_q <= ST_FULL;
					end
				end else begin
					sh_q <= at_inc;
					if (!found_q) begin
						status_q <= ST_ABSENT;
					end
				end
			end
		end
		if (state_q == S_SHIFT && issue) begin
			sh_q <= (mode_q == MODE_ADD) ? sh_dec : sh_inc;
		end
	end

	always_comb begin
		rslt.head_valid    = (fill_q != '0);
		rslt.head_id       = rslt.head_valid ? ID_W'(rd_id) : '0;
		rslt.head_priority = rslt.head_valid ? rd_prio : '0;
		rslt.entry_total   = TOTAL_W'(fill_q);
		rslt.status        = status_q;
	end

	// The count never passes the capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The shift pipeline never reads the entry that it writes in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
		else $error("read and write of the same entry in one cycle");

	// Entries are written only while shifting or inserting.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q == S_SHIFT || state_q == S_INSERT))
		else $error("entry write outside shift or insert");

	// An idle cycle without a new word leaves the count alone.
	a_idle_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !accept |=> $stable(fill_q))
		else $error("count changed while idle");

endmodule

[hdl/priority_warning_queue.sv]
// ----------------------------------------------------------------------------
// priority_warning_queue: sorted warning queue with unique IDs
// Holds up to CAPACITY (ID, priority) entries in one RAM, highest priority
// first, newest first among equal priorities; add, remove, clear and peek
// each return one result word with the head entry, count and status.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata: mode[1:0], warning_id[9:2], priority_req[25:10], zero
// m_axis    out  tdata: head_id, head_priority, entry_total, status;
//                tuser: head_valid
//
// Each operation runs to its end before the next word is taken. Add and
// remove are paced by the single read port of the entry RAM: one pass
// reads every entry to find the ID and the insert point, and, unless the
// add is refused or the ID is absent, a second pass moves the entries that
// lie behind the insert or remove point by one slot. Clear and peek go
// straight to the read of the head. Reset clears the count but not the RAM;
// no clearing pass is needed, since entries beyond the count are never read.
// The finished result sits in an output register, so a new word is taken
// while the previous result still waits on m_axis_tready.
//
module priority_warning_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], warning_id[9:2], priority_req[25:10], zero fill [31:26]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// head_id[7:0], head_priority[23:8], entry_total[29:24], status[31:30]
	output logic [31:0] m_axis_tdata,
	// head_valid[0]
	output logic [0:0]  m_axis_tuser
);

	import pwq_pkg::*;

	ram_req_t             ram_req;
	logic [ENTRY_W-1:0]   ram_rdata;
	rslt_t                rslt;
	logic                 rslt_valid;
	logic                 rslt_ready;
	logic                 out_valid_q;
	rslt_t                out_q;

	// The sequencer owns all reads and writes of the entry store.
	pwq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (mode_t'(s_axis_tdata[1:0])),
		.in_id      (s_axis_tdata[9:2]),
		.in_prio    (s_axis_tdata[25:10]),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	// Entry store: priority in the upper bits, ID in the lower bits.
	pwq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Output register: a result moves in when the register is empty or
	// is being emptied in the same cycle.
	assign rslt_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_ready) begin
			out_valid_q <= rslt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_ready && rslt_valid) begin
			out_q <= rslt;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_q.status, out_q.entry_total, out_q.head_priority,
		out_q.head_id};
	assign m_axis_tuser[0] = out_q.head_valid;

endmodule

[tb/tb_priority_warning_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_warning_queue: self-checking bench for the priority warning queue
// A short table of directed operations is followed by about a thousand random
// ones. The random words alternate between runs that fill the queue and runs
// that drain it, across four flow-control phases. The bench mirrors the
// sorted queue and checks every result word field by field. It also makes
// one long receiver hold-off, so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_priority_warning_queue;
	import pwq_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HALF_ITEMS   = 130;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 400;

	// One row of the directed table; want is used only when typed is set.
	typedef struct {
		mode_t             op;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		bit                typed;
		rslt_t             want;
	} op_row_t;

	localparam rslt_t EMPTY_DONE   = '{1'b0, 8'h00, 16'h0000, 6'd0, ST_DONE};
	localparam rslt_t EMPTY_ABSENT = '{1'b0, 8'h00, 16'h0000, 6'd0, ST_ABSENT};
	localparam rslt_t UNTYPED      = '{1'b0, 8'h00, 16'h0000, 6'd0, ST_DONE};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	// Mirror of the sorted queue, updated at each accepted input word.
	logic [ID_W-1:0]   shadow_id [CAPACITY];
	logic [PRIO_W-1:0] shadow_prio [CAPACITY];
	int                shadow_fill;

	rslt_t   awaited_reports[$];
	op_row_t op_table[$];

	// Side information that travels with the word on s_axis.
	bit    word_typed;
	rslt_t word_want;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int cycle_count;
	int words_taken;
	int reports_checked;
	int mismatches;
	int status_hits [4];

	priority_warning_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Appends one row to the directed table.
	function automatic void add_row(input mode_t op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input bit typed, input rslt_t want);
		op_row_t r;
		r.op    = op;
		r.id    = id;
		r.prio  = prio;
		r.typed = typed;
		r.want  = want;
		op_table.insert(op_table.size(), r);
	endfunction

	// Applies one operation to the mirror and returns the report it should give.
	function automatic rslt_t apply_queue_op(input mode_t op, input logic [ID_W-1:0] raw_id,
			input logic [PRIO_W-1:0] prio);
		logic [ID_W-1:0] key;
		int              hit;
		int              slot;
		status_t         st;
		rslt_t           rep;
		key = raw_id & ID_W'((1 << ID_BITS) - 1);
		hit = -1;
		st  = ST_DONE;
		for (int i = 0; i < shadow_fill; i++)
			if (hit < 0 && shadow_id[i] == key)
				hit = i;
		case (op)
			MODE_ADD: begin
				if (hit >= 0) begin
					st = ST_DUP;
				end else if (shadow_fill >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					// Insert ahead of the first entry whose priority is not above ours.
					slot = shadow_fill;
					for (int i = shadow_fill - 1; i >= 0; i--)
						if (prio >= shadow_prio[i])
							slot = i;
					for (int i = shadow_fill; i > slot; i--) begin
						shadow_id[i]   = shadow_id[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_id[slot]   = key;
					shadow_prio[slot] = prio;
					shadow_fill++;
				end
			end
			MODE_REMOVE: begin
				if (hit < 0) begin
					st = ST_ABSENT;
				end else begin
					for (int i = hit; i < shadow_fill - 1; i++) begin
						shadow_id[i]   = shadow_id[i+1];
						shadow_prio[i] = shadow_prio[i+1];
					end
					shadow_fill--;
				end
			end
			MODE_CLEAR: shadow_fill = 0;
			default: ;
		endcase
		rep.head_valid    = (shadow_fill > 0);
		rep.head_id       = (shadow_fill > 0) ? shadow_id[0] : '0;
		rep.head_priority = (shadow_fill > 0) ? shadow_prio[0] : '0;
		rep.entry_total   = TOTAL_W'(shadow_fill);
		rep.status        = st;
		return rep;
	endfunction

	// Offers one word, after an optional idle gap, and returns once it is taken.
	task automatic send_word(input mode_t op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input bit typed, input rslt_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, prio, id, op};
		word_typed    <= typed;
		word_want     <= want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_left;
		int holds_seen;
		hold_left      = 0;
		holds_seen     = 0;
		m_axis_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Predicts at each accepted input word and checks each accepted result word.
	always @(posedge clk) begin
		rslt_t predicted;
		rslt_t got;
		rslt_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = apply_queue_op(mode_t'(s_axis_tdata[1:0]), s_axis_tdata[9:2],
					s_axis_tdata[25:10]);
				awaited_reports.insert(awaited_reports.size(),
					word_typed ? word_want : predicted);
				words_taken++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.head_valid    = m_axis_tuser[0];
				got.head_id       = m_axis_tdata[7:0];
				got.head_priority = m_axis_tdata[23:8];
				got.entry_total   = m_axis_tdata[29:24];
				got.status        = status_t'(m_axis_tdata[31:30]);
				if (awaited_reports.size() == 0) begin
					$error("result word with nothing awaited: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					reports_checked++;
					status_hits[got.status]++;
					if (got.head_valid !== want.head_valid) begin
						$error("head_valid: expected %0d, got %0d", want.head_valid,
							got.head_valid);
						mismatches++;
					end
					if (got.head_id !== want.head_id) begin
						$error("head_id: expected %0h, got %0h", want.head_id, got.head_id);
						mismatches++;
					end
					if (got.head_priority !== want.head_priority) begin
						$error("head_priority: expected %0h, got %0h", want.head_priority,
							got.head_priority);
						mismatches++;
					end
					if (got.entry_total !== want.entry_total) begin
						$error("entry_total: expected %0d, got %0d", want.entry_total,
							got.entry_total);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still awaited", cycle_count,
			awaited_reports.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int                idle_of_phase [4];
		int                stall_of_phase [4];
		int                pick;
		int                add_pct;
		int                rem_pct;
		mode_t             op;
		logic [ID_W-1:0]   wid;
		logic [PRIO_W-1:0] wprio;
		op_row_t           row;

		idle_of_phase  = '{0, 49, 0, 30};
		stall_of_phase = '{0, 0, 49, 30};
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		word_typed      = 1'b0;
		word_want       = UNTYPED;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_requests   = 0;
		shadow_fill     = 0;
		words_taken     = 0;
		reports_checked = 0;
		mismatches      = 0;
		status_hits     = '{0, 0, 0, 0};

		// Directed table: empty queue, extremes, ties, duplicates, absent ids,
		// removal at the head, in the middle and at the tail, clear and peek.
		add_row(MODE_PEEK,   8'h00, 16'h0000, 1'b1, EMPTY_DONE);
		add_row(MODE_REMOVE, 8'h05, 16'h0000, 1'b1, EMPTY_ABSENT);
		add_row(MODE_ADD,    8'h00, 16'h0000, 1'b1,
			'{1'b1, 8'h00, 16'h0000, 6'd1, ST_DONE});
		add_row(MODE_ADD,    8'hFF, 16'hFFFF, 1'b1,
			'{1'b1, 8'hFF, 16'hFFFF, 6'd2, ST_DONE});
		add_row(MODE_ADD,    8'h10, 16'hFFFF, 1'b0, UNTYPED);
		add_row(MODE_ADD,    8'hFF, 16'h1234, 1'b0, UNTYPED);
		add_row(MODE_ADD,    8'h20, 16'h8000, 1'b0, UNTYPED);
		add_row(MODE_ADD,    8'h21, 16'h8000, 1'b0, UNTYPED);
		add_row(MODE_PEEK,   8'hC3, 16'h5A5A, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'h10, 16'h0000, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'h21, 16'h0000, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'h00, 16'hFFFF, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'h99, 16'h0000, 1'b0, UNTYPED);
		add_row(MODE_CLEAR,  8'hFF, 16'hFFFF, 1'b1, EMPTY_DONE);
		add_row(MODE_PEEK,   8'h00, 16'h0000, 1'b1, EMPTY_DONE);
		add_row(MODE_ADD,    8'hAA, 16'h5555, 1'b0, UNTYPED);
		add_row(MODE_ADD,    8'h55, 16'hAAAA, 1'b0, UNTYPED);
		add_row(MODE_ADD,    8'h01, 16'h0001, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'hAA, 16'h0000, 1'b0, UNTYPED);
		add_row(MODE_CLEAR,  8'h00, 16'h0000, 1'b1, EMPTY_DONE);
		add_row(MODE_CLEAR,  8'h00, 16'h0000, 1'b1, EMPTY_DONE);
		add_row(MODE_ADD,    8'h00, 16'hFFFF, 1'b0, UNTYPED);
		add_row(MODE_PEEK,   8'hFF, 16'h0000, 1'b0, UNTYPED);
		add_row(MODE_REMOVE, 8'h00, 16'h0000, 1'b0, UNTYPED);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_table[k]) begin
			row = op_table[k];
			send_word(row.op, row.id, row.prio, row.typed, row.want);
		end

		// Random part: each flow-control phase has a filling half and a
		// draining half, so the queue goes full and refuses adds, then empties.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_of_phase[p];
			recv_stall_pct = stall_of_phase[p];
			if (p == 0)
				hold_requests++;
			for (int half = 0; half < 2; half++) begin
				add_pct = (half == 0) ? 75 : 35;
				rem_pct = (half == 0) ? 12 : 55;
				for (int n = 0; n < HALF_ITEMS; n++) begin
					pick = $urandom_range(99);
					if (pick < add_pct)
						op = MODE_ADD;
					else if (pick < add_pct + rem_pct)
						op = MODE_REMOVE;
					else if (pick < 98 + half)
						op = MODE_PEEK;
					else
						op = MODE_CLEAR;
					// Half the ids hit a stored entry, to reach duplicates and removes.
					if (shadow_fill > 0 && $urandom_range(1) == 1)
						wid = shadow_id[$urandom_range(shadow_fill - 1)];
					else
						wid = ID_W'($urandom_range(255));
					case ($urandom_range(3))
						0: wprio = (shadow_fill > 0) ?
							shadow_prio[$urandom_range(shadow_fill - 1)] : 16'h8000;
						1: wprio = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
						default: wprio = PRIO_W'($urandom_range(16'hFFFF));
					endcase
					send_word(op, wid, wprio, 1'b0, UNTYPED);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		recv_stall_pct = 0;
		@(posedge clk);
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations in %0d cycles, %0d results checked.", words_taken,
			cycle_count, reports_checked);
		$display("Status seen: %0d done, %0d duplicate, %0d full, %0d absent.",
			status_hits[ST_DONE], status_hits[ST_DUP], status_hits[ST_FULL],
			status_hits[ST_ABSENT]);
		if (mismatches == 0 && awaited_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[priority_warning_queue.f]
hdl/pwq_pkg.sv
hdl/pwq_ram.sv
hdl/pwq_ctrl.sv
hdl/priority_warning_queue.sv
tb/tb_priority_warning_queue.sv
